// ===== src/fbaq_pkg.sv =====
// Package for the frame-bucketed arc queue: request kinds, status codes,
// sequencer states and payload widths. No dependencies.
package fbaq_pkg;

    localparam int KIND_W   = 3;
    localparam int WORD_W   = 20;
    localparam int FRAME_W  = 9;
    localparam int END_W    = 8;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 11;
    localparam int ARC_W    = WORD_W + 2 * END_W;

    localparam logic [KIND_W-1:0] KIND_EXTEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT_CLR,
        S_ADD_RD,
        S_ADD_WR,
        S_LK_RD,
        S_LK_WAIT,
        S_RD_WAIT,
        S_PS_RD,
        S_PS_WR,
        S_SC_RD,
        S_SC_SLOT,
        S_SC_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  word_id;
        logic [FRAME_W-1:0] frame;
        logic [END_W-1:0]   end_frame;
        logic [INDEX_W-1:0] arc_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [WORD_W-1:0]   arc_word;
        logic [END_W-1:0]    arc_start;
        logic [END_W-1:0]    arc_end;
    } rsp_t;

endpackage

// ===== src/fbaq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on fbaq_pkg.
interface fbaq_req_if;
    logic                        valid;
    logic                        ready;
    logic [fbaq_pkg::KIND_W-1:0]  kind;
    logic [fbaq_pkg::WORD_W-1:0]  word_id;
    logic [fbaq_pkg::FRAME_W-1:0] frame;
    logic [fbaq_pkg::END_W-1:0]   end_frame;
    logic [fbaq_pkg::INDEX_W-1:0] arc_index;
    modport source (output valid, kind, word_id, frame, end_frame, arc_index, input ready);
    modport sink (input valid, kind, word_id, frame, end_frame, arc_index, output ready);
endinterface

interface fbaq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbaq_pkg::STATUS_W-1:0] status;
    logic [fbaq_pkg::VALUE_W-1:0]  value;
    logic [fbaq_pkg::WORD_W-1:0]   arc_word;
    logic [fbaq_pkg::END_W-1:0]    arc_start;
    logic [fbaq_pkg::END_W-1:0]    arc_end;
    modport source (output valid, status, value, arc_word, arc_start, arc_end, input ready);
    modport sink (input valid, status, value, arc_word, arc_start, arc_end, output ready);
endinterface

// ===== src/fbaq_ram.sv =====
// Single-write, single-read memory with a registered read port.
// No dependencies.
module fbaq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/frame_bucketed_arc_queue_core.sv =====
// Top level of the frame-bucketed arc queue: sequencer, counters and memories.
// Depends on fbaq_pkg, fbaq_if and fbaq_ram.
//
// Requests arrive on req (valid/ready) and each gives exactly one response on
// rsp. The block handles one request at a time and drops ready while busy.
// Arcs are counted per start frame in a window; commit turns the counts into
// first indices by a prefix sum and scatters the staged arcs into frame order.
// Each kind runs its own states before the response is registered: add reads and
// writes the frame count (a refused add stops after the read), lookup reads the
// first index, read waits on the sorted memory, clear and unused kinds answer
// directly, extend zeroes the count of each opened frame, and commit runs the
// prefix sum over the window frames, then a read, slot and write step per staged arc.
// The response is held in an output register until taken; the next request is
// accepted in the cycle after the response is taken.
// Reset empties the window and all counts; memory contents are
// left undefined and are never used before being written.
module frame_bucketed_arc_queue_core #(
    parameter int MAX_FRAMES = 256,
    parameter int MAX_ARCS   = 1024
) (
    input logic clk,
    input logic rst_n,
    fbaq_req_if.sink   req,
    fbaq_rsp_if.source rsp
);

    localparam int FA_W = $clog2(MAX_FRAMES);
    localparam int AA_W = $clog2(MAX_ARCS);
    localparam int FC_W = $clog2(MAX_FRAMES + 1);
    localparam int AC_W = $clog2(MAX_ARCS + 1);
    localparam int CMP_W = (FC_W > fbaq_pkg::FRAME_W) ? FC_W : fbaq_pkg::FRAME_W;
    localparam int ACMP_W = (AC_W > fbaq_pkg::INDEX_W) ? AC_W : fbaq_pkg::INDEX_W;

    fbaq_pkg::state_t state_reg, state_next;
    fbaq_pkg::req_t   req_reg;
    fbaq_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg;

    logic [FC_W-1:0] win_start_reg, win_start_next;
    logic [FC_W-1:0] win_end_reg, win_end_next;
    logic [AC_W-1:0] committed_reg, committed_next;
    logic [AC_W-1:0] staged_reg, staged_next;
    logic [FC_W-1:0] fptr_reg, fptr_next;
    logic [AC_W-1:0] aptr_reg, aptr_next;
    logic [AC_W-1:0] run_reg, run_next;
    logic [FA_W-1:0] sfr_reg, sfr_next;

    logic [AC_W-1:0] slot_mem   [MAX_FRAMES];
    logic [AC_W-1:0] cursor_mem [MAX_FRAMES];
    logic            slot_we, cursor_we;
    logic [FA_W-1:0] slot_waddr, slot_raddr, cursor_waddr, cursor_raddr;
    logic [AC_W-1:0] slot_wdata, cursor_wdata, slot_rdata, cursor_rdata;

    logic                      stg_we, srt_we;
    logic [AA_W-1:0]           stg_waddr, stg_raddr, srt_waddr, srt_raddr;
    logic [fbaq_pkg::ARC_W-1:0] stg_wdata, stg_rdata, srt_rdata;

    logic [CMP_W-1:0]  f_req, ws_c, we_c;
    logic [ACMP_W-1:0] idx_req, com_c;
    logic              accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == fbaq_pkg::S_IDLE) && !rsp_valid_reg;
    assign f_req     = CMP_W'(req_reg.frame);
    assign ws_c      = CMP_W'(win_start_reg);
    assign we_c      = CMP_W'(win_end_reg);
    assign idx_req   = ACMP_W'(req_reg.arc_index);
    assign com_c     = ACMP_W'(committed_reg);

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata <= slot_mem[slot_raddr];
        if (cursor_we)
        begin
            cursor_mem[cursor_waddr] <= cursor_wdata;
        end
        cursor_rdata <= cursor_mem[cursor_raddr];
    end

    fbaq_ram #(.DEPTH(MAX_ARCS), .WIDTH(fbaq_pkg::ARC_W)) u_staged (
        .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
        .raddr(stg_raddr), .rdata(stg_rdata)
    );

    fbaq_ram #(.DEPTH(MAX_ARCS), .WIDTH(fbaq_pkg::ARC_W)) u_sorted (
        .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(stg_rdata),
        .raddr(srt_raddr), .rdata(srt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbaq_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            win_start_reg <= '0;
            win_end_reg   <= '0;
            committed_reg <= '0;
            staged_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            win_start_reg <= win_start_next;
            win_end_reg   <= win_end_next;
            committed_reg <= committed_next;
            staged_reg    <= staged_next;
            if (state_reg == fbaq_pkg::S_DONE)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.kind      <= req.kind;
            req_reg.word_id   <= req.word_id;
            req_reg.frame     <= req.frame;
            req_reg.end_frame <= req.end_frame;
            req_reg.arc_index <= req.arc_index;
        end
        rsp_reg  <= rsp_next;
        fptr_reg <= fptr_next;
        aptr_reg <= aptr_next;
        run_reg  <= run_next;
        sfr_reg  <= sfr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fbaq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.kind)
                        fbaq_pkg::KIND_EXTEND:
                        begin
                            state_next = fbaq_pkg::S_EXT_CLR;
                        end
                        fbaq_pkg::KIND_ADD:
                        begin
                            state_next = fbaq_pkg::S_ADD_RD;
                        end
                        fbaq_pkg::KIND_COMMIT:
                        begin
                            state_next = fbaq_pkg::S_PS_RD;
                        end
                        fbaq_pkg::KIND_LOOKUP:
                        begin
                            state_next = fbaq_pkg::S_LK_RD;
                        end
                        fbaq_pkg::KIND_READ:
                        begin
                            state_next = fbaq_pkg::S_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = fbaq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            fbaq_pkg::S_EXT_CLR:
            begin
                if (f_req <= we_c || f_req > CMP_W'(MAX_FRAMES) ||
                    CMP_W'(fptr_reg) + 1'b1 >= f_req)
                begin
                    state_next = fbaq_pkg::S_DONE;
                end
            end
            fbaq_pkg::S_ADD_RD:
            begin
                if (f_req < ws_c || f_req >= we_c ||
                    committed_reg + staged_reg >= AC_W'(MAX_ARCS))
                begin
                    state_next = fbaq_pkg::S_DONE;
                end
                else
                begin
                    state_next = fbaq_pkg::S_ADD_WR;
                end
            end
            fbaq_pkg::S_ADD_WR:
            begin
                state_next = fbaq_pkg::S_DONE;
            end
            fbaq_pkg::S_LK_RD:
            begin
                state_next = fbaq_pkg::S_LK_WAIT;
            end
            fbaq_pkg::S_LK_WAIT:
            begin
                state_next = fbaq_pkg::S_DONE;
            end
            fbaq_pkg::S_RD_WAIT:
            begin
                state_next = fbaq_pkg::S_DONE;
            end
            fbaq_pkg::S_PS_RD:
            begin
                if (fptr_reg >= win_end_reg)
                begin
                    state_next = (staged_reg == '0) ? fbaq_pkg::S_DONE : fbaq_pkg::S_SC_RD;
                end
                else
                begin
                    state_next = fbaq_pkg::S_PS_WR;
                end
            end
            fbaq_pkg::S_PS_WR:
            begin
                state_next = fbaq_pkg::S_PS_RD;
            end
            fbaq_pkg::S_SC_RD:
            begin
                state_next = fbaq_pkg::S_SC_SLOT;
            end
            fbaq_pkg::S_SC_SLOT:
            begin
                state_next = fbaq_pkg::S_SC_WR;
            end
            fbaq_pkg::S_SC_WR:
            begin
                state_next = (aptr_reg >= staged_reg) ? fbaq_pkg::S_DONE : fbaq_pkg::S_SC_RD;
            end
            fbaq_pkg::S_DONE:
            begin
                state_next = fbaq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fbaq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        win_start_next = win_start_reg;
        win_end_next   = win_end_reg;
        committed_next = committed_reg;
        staged_next    = staged_reg;
        fptr_next      = fptr_reg;
        aptr_next      = aptr_reg;
        run_next       = run_reg;
        sfr_next       = sfr_reg;
        slot_we        = 1'b0;
        slot_waddr     = fptr_reg[FA_W-1:0];
        slot_wdata     = '0;
        slot_raddr     = req_reg.frame[FA_W-1:0];
        cursor_we      = 1'b0;
        cursor_waddr   = fptr_reg[FA_W-1:0];
        cursor_wdata   = run_reg;
        cursor_raddr   = sfr_reg;
        stg_we         = 1'b0;
        stg_waddr      = staged_reg[AA_W-1:0];
        stg_wdata      = {req_reg.word_id, req_reg.frame[fbaq_pkg::END_W-1:0],
                          req_reg.end_frame};
        stg_raddr      = aptr_reg[AA_W-1:0];
        srt_we         = 1'b0;
        srt_waddr      = cursor_rdata[AA_W-1:0];
        srt_raddr      = req_reg.arc_index[AA_W-1:0];
        unique case (state_reg)
            fbaq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '0;
                end
                fptr_next = (accept && req.kind == fbaq_pkg::KIND_COMMIT) ?
                            win_start_reg : win_end_reg;
                aptr_next = '0;
                run_next  = committed_reg;
                slot_raddr = req.frame[FA_W-1:0];
                srt_raddr  = req.arc_index[AA_W-1:0];
            end
            fbaq_pkg::S_EXT_CLR:
            begin
                if (f_req == we_c)
                begin
                    rsp_next.status = fbaq_pkg::ST_OK;
                end
                else if (f_req < we_c || f_req > CMP_W'(MAX_FRAMES))
                begin
                    rsp_next.status = fbaq_pkg::ST_BAD;
                end
                else
                begin
                    slot_we   = 1'b1;
                    fptr_next = fptr_reg + 1'b1;
                    if (CMP_W'(fptr_reg) + 1'b1 >= f_req)
                    begin
                        win_end_next  = FC_W'(req_reg.frame);
                        rsp_next.value = fbaq_pkg::VALUE_W'(f_req - ws_c);
                    end
                end
            end
            fbaq_pkg::S_ADD_RD:
            begin
                if (f_req < ws_c || f_req >= we_c)
                begin
                    rsp_next.status = fbaq_pkg::ST_OUTSIDE;
                end
                else if (committed_reg + staged_reg >= AC_W'(MAX_ARCS))
                begin
                    rsp_next.status = fbaq_pkg::ST_FULL;
                end
            end
            fbaq_pkg::S_ADD_WR:
            begin
                slot_we     = 1'b1;
                slot_waddr  = req_reg.frame[FA_W-1:0];
                slot_wdata  = slot_rdata + 1'b1;
                stg_we      = 1'b1;
                staged_next = staged_reg + 1'b1;
            end
            fbaq_pkg::S_LK_RD:
            begin
                if (f_req >= CMP_W'(MAX_FRAMES))
                begin
                    rsp_next.status = fbaq_pkg::ST_BAD;
                end
                else if (f_req >= ws_c)
                begin
                    rsp_next.status = fbaq_pkg::ST_OUTSIDE;
                end
            end
            fbaq_pkg::S_LK_WAIT:
            begin
                if (rsp_reg.status == fbaq_pkg::ST_OK)
                begin
                    if (slot_rdata >= committed_reg)
                    begin
                        rsp_next.status = fbaq_pkg::ST_OUTSIDE;
                    end
                    else
                    begin
                        rsp_next.value = fbaq_pkg::VALUE_W'(slot_rdata);
                    end
                end
            end
            fbaq_pkg::S_RD_WAIT:
            begin
                if (idx_req >= com_c || idx_req >= ACMP_W'(MAX_ARCS))
                begin
                    rsp_next.status = fbaq_pkg::ST_OUTSIDE;
                end
                else
                begin
                    {rsp_next.arc_word, rsp_next.arc_start, rsp_next.arc_end} = srt_rdata;
                end
            end
            fbaq_pkg::S_PS_RD:
            begin
                slot_raddr = fptr_reg[FA_W-1:0];
                if (fptr_reg >= win_end_reg && staged_reg == '0)
                begin
                    win_start_next = win_end_reg;
                end
            end
            fbaq_pkg::S_PS_WR:
            begin
                slot_we    = 1'b1;
                slot_wdata = run_reg;
                cursor_we  = 1'b1;
                run_next   = run_reg + slot_rdata;
                fptr_next  = fptr_reg + 1'b1;
            end
            fbaq_pkg::S_SC_RD:
            begin
                aptr_next = aptr_reg;
            end
            fbaq_pkg::S_SC_SLOT:
            begin
                aptr_next    = aptr_reg + 1'b1;
                cursor_raddr = stg_rdata[fbaq_pkg::END_W +: FA_W];
                sfr_next     = stg_rdata[fbaq_pkg::END_W +: FA_W];
            end
            fbaq_pkg::S_SC_WR:
            begin
                srt_we       = (cursor_rdata < AC_W'(MAX_ARCS));
                cursor_we    = 1'b1;
                cursor_waddr = sfr_reg;
                cursor_wdata = cursor_rdata + 1'b1;
                if (aptr_reg >= staged_reg)
                begin
                    rsp_next.value = fbaq_pkg::VALUE_W'(staged_reg);
                    win_start_next = win_end_reg;
                    committed_next = committed_reg + staged_reg;
                    staged_next    = '0;
                end
            end
            fbaq_pkg::S_DONE:
            begin
                if (req_reg.kind == fbaq_pkg::KIND_CLEAR)
                begin
                    win_start_next = '0;
                    win_end_next   = '0;
                    committed_next = '0;
                    staged_next    = '0;
                end
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_reg.status;
    assign rsp.value     = rsp_reg.value;
    assign rsp.arc_word  = rsp_reg.arc_word;
    assign rsp.arc_start = rsp_reg.arc_start;
    assign rsp.arc_end   = rsp_reg.arc_end;

endmodule

// ===== src/fbaq_checker.sv =====
// Port-level checks for the arc queue core, bound to the top level.
// Depends on fbaq_pkg.
module fbaq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fbaq_pkg::STATUS_W-1:0] rsp_status,
    input logic [fbaq_pkg::WORD_W-1:0]   rsp_arc_word
);

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a response is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready stayed high after an accepted request");

    a_rsp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
        else $error("stalled response changed");

    a_arc_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != fbaq_pkg::ST_OK) |-> (rsp_arc_word == '0))
        else $error("arc fields nonzero on error status");

endmodule

bind frame_bucketed_arc_queue_core fbaq_checker u_fbaq_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_arc_word(rsp.arc_word)
);

// ===== dv/tb_frame_bucketed_arc_queue_core.sv =====
// Self-checking testbench for frame_bucketed_arc_queue_core: a directed table and random
// window/add/commit rounds are checked against a built-in predictor or fixed values;
// rounds run under varied idling. Depends on fbaq_pkg, fbaq_if and the block's sources.
`timescale 1ns / 100ps

module tb_frame_bucketed_arc_queue_core;

    localparam int N_FRAMES = 256;
    localparam int N_ARCS   = 1024;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [fbaq_pkg::WORD_W-1:0] word;
        logic [fbaq_pkg::END_W-1:0]  start;
        logic [fbaq_pkg::END_W-1:0]  fin;
    } arc_t;

    typedef struct {
        fbaq_pkg::req_t                r;
        bit                            typed;
        logic [fbaq_pkg::STATUS_W-1:0] st;
        logic [fbaq_pkg::VALUE_W-1:0]  val;
    } row_t;

    logic clk;
    logic rst_n;
    fbaq_req_if req_ch ();
    fbaq_rsp_if rsp_ch ();

    frame_bucketed_arc_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    int unsigned slot_m[N_FRAMES];
    int unsigned cursor_m[N_FRAMES];
    arc_t        sorted_m[N_ARCS];
    arc_t        staged_m[N_ARCS];
    int unsigned win_start;
    int unsigned win_end;
    int unsigned n_committed;
    int unsigned n_staged;

    fbaq_pkg::rsp_t pending_rsps[$];
    row_t        directed_rows[$];
    int          errors;
    int          n_reqs;
    int          n_rsps;
    int          src_idle;
    int          snk_stall;
    int          quiet_cycles;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic fbaq_pkg::rsp_t arc_queue_predict(fbaq_pkg::req_t r);
        fbaq_pkg::rsp_t o;
        int unsigned i;
        int unsigned run;
        int unsigned cnt;
        int unsigned s;
        int unsigned pos;
        o = '0;
        case (r.kind)
            fbaq_pkg::KIND_EXTEND:
            begin
                if (r.frame == win_end)
                    o.status = fbaq_pkg::ST_OK;
                else if (r.frame < win_end || r.frame > N_FRAMES)
                    o.status = fbaq_pkg::ST_BAD;
                else
                begin
                    for (i = win_end; i < r.frame; i++)
                        slot_m[i] = 0;
                    win_end = r.frame;
                    o.value = win_end - win_start;
                end
            end
            fbaq_pkg::KIND_ADD:
            begin
                if (r.frame < win_start || r.frame >= win_end)
                    o.status = fbaq_pkg::ST_OUTSIDE;
                else if (n_committed + n_staged >= N_ARCS)
                    o.status = fbaq_pkg::ST_FULL;
                else
                begin
                    staged_m[n_staged].word  = r.word_id;
                    staged_m[n_staged].start = r.frame[fbaq_pkg::END_W-1:0];
                    staged_m[n_staged].fin   = r.end_frame;
                    n_staged++;
                    slot_m[r.frame]++;
                end
            end
            fbaq_pkg::KIND_COMMIT:
            begin
                if (win_end > win_start)
                begin
                    run = n_committed;
                    for (i = win_start; i < win_end; i++)
                    begin
                        cnt = slot_m[i];
                        slot_m[i] = run;
                        cursor_m[i] = run;
                        run += cnt;
                    end
                    for (i = 0; i < n_staged; i++)
                    begin
                        s = staged_m[i].start;
                        pos = cursor_m[s];
                        if (pos < N_ARCS)
                            sorted_m[pos] = staged_m[i];
                        cursor_m[s] = pos + 1;
                    end
                    o.value = n_staged;
                    win_start = win_end;
                    n_committed += n_staged;
                    n_staged = 0;
                end
            end
            fbaq_pkg::KIND_LOOKUP:
            begin
                if (r.frame >= N_FRAMES)
                    o.status = fbaq_pkg::ST_BAD;
                else if (r.frame >= win_start || slot_m[r.frame] >= n_committed)
                    o.status = fbaq_pkg::ST_OUTSIDE;
                else
                    o.value = slot_m[r.frame];
            end
            fbaq_pkg::KIND_READ:
            begin
                if (r.arc_index >= n_committed)
                    o.status = fbaq_pkg::ST_OUTSIDE;
                else
                begin
                    o.arc_word  = sorted_m[r.arc_index].word;
                    o.arc_start = sorted_m[r.arc_index].start;
                    o.arc_end   = sorted_m[r.arc_index].fin;
                end
            end
            fbaq_pkg::KIND_CLEAR:
            begin
                win_start = 0;
                win_end = 0;
                n_committed = 0;
                n_staged = 0;
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    task automatic send_request(fbaq_pkg::req_t r, bit typed, fbaq_pkg::rsp_t typed_rsp);
        fbaq_pkg::rsp_t p;
        while ($urandom_range(0, 99) < src_idle)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.kind      = r.kind;
        req_ch.word_id   = r.word_id;
        req_ch.frame     = r.frame;
        req_ch.end_frame = r.end_frame;
        req_ch.arc_index = r.arc_index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        p = arc_queue_predict(r);
        pending_rsps.push_back(typed ? typed_rsp : p);
        n_reqs++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic send_random(logic [fbaq_pkg::KIND_W-1:0] k,
                               logic [fbaq_pkg::FRAME_W-1:0] f,
                               logic [fbaq_pkg::INDEX_W-1:0] idx);
        fbaq_pkg::req_t r;
        r.kind      = k;
        r.word_id   = $urandom;
        r.frame     = f;
        r.end_frame = $urandom;
        r.arc_index = idx;
        send_request(r, 1'b0, '0);
    endtask

    task automatic add_row(logic [fbaq_pkg::KIND_W-1:0] k, logic [fbaq_pkg::WORD_W-1:0] w,
                           logic [fbaq_pkg::FRAME_W-1:0] f, logic [fbaq_pkg::END_W-1:0] e,
                           logic [fbaq_pkg::INDEX_W-1:0] idx, bit typed,
                           logic [fbaq_pkg::STATUS_W-1:0] st,
                           logic [fbaq_pkg::VALUE_W-1:0] val);
        row_t row;
        row.r     = '{kind: k, word_id: w, frame: f, end_frame: e, arc_index: idx};
        row.typed = typed;
        row.st    = st;
        row.val   = val;
        directed_rows.push_back(row);
    endtask

    task automatic run_round(int fill);
        int          n;
        int unsigned lo;
        int unsigned hi;
        int unsigned top;
        if (win_start >= N_FRAMES - 1 || $urandom_range(0, 99) < 2)
            send_random(fbaq_pkg::KIND_CLEAR, '0, '0);
        top = win_end + $urandom_range(1, 8);
        if (top > N_FRAMES)
            top = N_FRAMES;
        send_random(fbaq_pkg::KIND_EXTEND, top[fbaq_pkg::FRAME_W-1:0], '0);
        lo = win_start;
        hi = win_end;
        n = fill ? 1100 : $urandom_range(0, 12);
        repeat (n)
        begin
            if (hi > lo && (fill || $urandom_range(0, 9) < 8))
                send_random(fbaq_pkg::KIND_ADD, $urandom_range(lo, hi - 1), '0);
            else
                send_random(fbaq_pkg::KIND_ADD, $urandom, '0);
        end
        if ($urandom_range(0, 9) == 0)
            send_random(fbaq_pkg::KIND_EXTEND, $urandom, '0);
        send_random(fbaq_pkg::KIND_COMMIT, '0, '0);
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 3) != 0 && win_start > 0)
                send_random(fbaq_pkg::KIND_LOOKUP, $urandom_range(0, win_start - 1), '0);
            else
                send_random(fbaq_pkg::KIND_LOOKUP, $urandom, '0);
            if ($urandom_range(0, 3) != 0 && n_committed > 0)
                send_random(fbaq_pkg::KIND_READ, '0, $urandom_range(0, n_committed - 1));
            else
                send_random(fbaq_pkg::KIND_READ, '0, $urandom);
        end
        if ($urandom_range(0, 19) == 0)
            send_random($urandom_range(6, 7), $urandom, $urandom);
    endtask

    always @(negedge clk)
        rsp_ch.ready = ($urandom_range(0, 99) >= snk_stall);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_rsps++;
            if (pending_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request waiting: status %0d value %0d",
                         $time, rsp_ch.status, rsp_ch.value);
            end
            else
            begin
                fbaq_pkg::rsp_t e;
                e = pending_rsps.pop_front();
                if (rsp_ch.status !== e.status || rsp_ch.value !== e.value ||
                    rsp_ch.arc_word !== e.arc_word || rsp_ch.arc_start !== e.arc_start ||
                    rsp_ch.arc_end !== e.arc_end)
                begin
                    errors++;
                    $display({"%0t: mismatch expected st %0d val %0d arc %h/%0d/%0d,",
                              " got st %0d val %0d arc %h/%0d/%0d"},
                             $time, e.status, e.value, e.arc_word, e.arc_start, e.arc_end,
                             rsp_ch.status, rsp_ch.value, rsp_ch.arc_word,
                             rsp_ch.arc_start, rsp_ch.arc_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        fbaq_pkg::rsp_t tr;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.word_id = '0;
        req_ch.frame = '0;
        req_ch.end_frame = '0;
        req_ch.arc_index = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        n_reqs = 0;
        n_rsps = 0;
        src_idle = 0;
        snk_stall = 0;
        quiet_cycles = 0;
        win_start = 0;
        win_end = 0;
        n_committed = 0;
        n_staged = 0;
        foreach (slot_m[i])
        begin
            slot_m[i] = 0;
            cursor_m[i] = 0;
        end
        foreach (sorted_m[i])
        begin
            sorted_m[i] = '{0, 0, 0};
            staged_m[i] = '{0, 0, 0};
        end

        add_row(fbaq_pkg::KIND_LOOKUP, 0, 0, 0, 0, 1, fbaq_pkg::ST_OUTSIDE, 0);
        add_row(fbaq_pkg::KIND_READ, 0, 0, 0, 0, 1, fbaq_pkg::ST_OUTSIDE, 0);
        add_row(fbaq_pkg::KIND_LOOKUP, 0, 256, 0, 0, 1, fbaq_pkg::ST_BAD, 0);
        add_row(fbaq_pkg::KIND_LOOKUP, 0, 511, 0, 0, 1, fbaq_pkg::ST_BAD, 0);
        add_row(fbaq_pkg::KIND_EXTEND, 0, 257, 0, 0, 1, fbaq_pkg::ST_BAD, 0);
        add_row(fbaq_pkg::KIND_ADD, 20'h12345, 0, 0, 0, 1, fbaq_pkg::ST_OUTSIDE, 0);
        add_row(fbaq_pkg::KIND_COMMIT, 0, 0, 0, 0, 1, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_EXTEND, 0, 0, 0, 0, 1, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_EXTEND, 0, 4, 0, 0, 1, fbaq_pkg::ST_OK, 4);
        add_row(fbaq_pkg::KIND_EXTEND, 0, 2, 0, 0, 1, fbaq_pkg::ST_BAD, 0);
        add_row(fbaq_pkg::KIND_ADD, 20'hFFFFF, 3, 8'hFF, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_ADD, 20'h00000, 0, 8'h00, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_ADD, 20'hA5A5A, 3, 8'h5A, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_ADD, 20'h11111, 4, 8'h01, 0, 1, fbaq_pkg::ST_OUTSIDE, 0);
        add_row(fbaq_pkg::KIND_EXTEND, 0, 6, 0, 0, 1, fbaq_pkg::ST_OK, 6);
        add_row(fbaq_pkg::KIND_ADD, 20'h5A5A5, 5, 8'hA5, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_COMMIT, 0, 0, 0, 0, 1, fbaq_pkg::ST_OK, 4);
        add_row(fbaq_pkg::KIND_LOOKUP, 0, 3, 0, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_LOOKUP, 0, 4, 0, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_READ, 0, 0, 0, 1, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_READ, 0, 0, 0, 1023, 1, fbaq_pkg::ST_OUTSIDE, 0);
        add_row(6, 20'hFFFFF, 511, 8'hFF, 1023, 1, fbaq_pkg::ST_OK, 0);
        add_row(7, 20'hFFFFF, 511, 8'hFF, 1023, 1, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_EXTEND, 0, 256, 0, 0, 1, fbaq_pkg::ST_OK, 250);
        add_row(fbaq_pkg::KIND_ADD, 20'h0F0F0, 255, 8'hFF, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_COMMIT, 0, 0, 0, 0, 1, fbaq_pkg::ST_OK, 1);
        add_row(fbaq_pkg::KIND_LOOKUP, 0, 255, 0, 0, 0, fbaq_pkg::ST_OK, 0);
        add_row(fbaq_pkg::KIND_CLEAR, 0, 0, 0, 0, 1, fbaq_pkg::ST_OK, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            tr = '0;
            tr.status = directed_rows[i].st;
            tr.value  = directed_rows[i].val;
            send_request(directed_rows[i].r, directed_rows[i].typed, tr);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle  = (ph == 1) ? 88 : (ph == 3) ? 22 : 0;
            snk_stall = (ph == 2) ? 88 : (ph == 3) ? 22 : 0;
            if (ph == 0)
            begin
                send_random(fbaq_pkg::KIND_CLEAR, '0, '0);
                run_round(1);
                send_random(fbaq_pkg::KIND_CLEAR, '0, '0);
            end
            while (n_reqs < 1250 + ph * 135)
                run_round(0);
        end

        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses over four idling phases,", n_reqs,
                 n_rsps);
        $display("including a fill past capacity, window extends, commits, lookups and reads.");
        if (errors == 0 && pending_rsps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/fbaq_pkg.sv
src/fbaq_if.sv
src/fbaq_ram.sv
src/frame_bucketed_arc_queue_core.sv
src/fbaq_checker.sv
dv/tb_frame_bucketed_arc_queue_core.sv
